// ===== hdl/accelerating_autorepeat_stepper_defines.svh =====
// Assertion helpers for the stepper RTL.
`ifndef ACCELERATING_AUTOREPEAT_STEPPER_DEFINES_SVH
`define ACCELERATING_AUTOREPEAT_STEPPER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define AAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define AAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/aas_pkg.sv =====
package aas_pkg;

  // timing constants, ms
  localparam logic [10:0] HOLD_DELAY_MS  = 11'd420;
  localparam logic [10:0] MULT2_MS       = 11'd700;
  localparam logic [10:0] RAMP_MS        = 11'd1200;
  localparam logic [10:0] MULT4_MS       = 11'd1800;
  localparam logic [6:0]  REPEAT_SLOW_MS = 7'd92;
  localparam logic [6:0]  REPEAT_FAST_MS = 7'd36;
  localparam logic [5:0]  EASE_SPAN      = 6'd56;   // slow - fast

  // t = floor((h*65536 + 600) / 1200) = floor((h*4096 + 37) / 75)
  localparam logic [5:0]  RAMP_BIAS      = 6'd37;
  localparam logic [22:0] RECIP_75       = 23'd7158279;  // ceil(2^29 / 75)

  // shared multiplier widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // config port
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_MIN_VALUE = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE = 2'd2;
  localparam logic [1:0] REG_ENABLED   = 2'd3;

  typedef struct packed {
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [14:0]        step;
    logic               enabled;
  } cfg_view_t;

  typedef struct packed {
    logic        start;
    logic [10:0] held;
  } ivl_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] interval;
  } ivl_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SIDE = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } top_state_t;

  typedef enum logic [4:0] {
    IV_IDLE   = 5'b00001,
    IV_SQUARE = 5'b00010,
    IV_CUBE   = 5'b00100,
    IV_SCALE  = 5'b01000,
    IV_FIN    = 5'b10000
  } ivl_state_t;

endpackage

// ===== hdl/aas_in_if.sv =====
interface aas_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               up_pressed;
  logic               down_pressed;
  logic signed [15:0] current_value;

  modport source (output valid, now_ms, up_pressed, down_pressed, current_value,
                  input ready);
  modport sink   (input valid, now_ms, up_pressed, down_pressed, current_value,
                  output ready);
endinterface

// ===== hdl/aas_out_if.sv =====
interface aas_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_value;
  logic               value_changed;

  modport source (output valid, new_value, value_changed, input ready);
  modport sink   (input valid, new_value, value_changed, output ready);
endinterface

// ===== hdl/accelerating_autorepeat_stepper.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    now_ms, up_pressed, down_pressed, current_value
// out_ch   out  valid/ready    new_value, value_changed
// cfg_*    in   APB write/read min_value, max_value, step_size, enabled
//
// Sequence per sample: accept, up side, down side, result; a due repeat with
//   a held time of 1..1199 ms waits on that side for the interval
//   multiplies in the shared multiplier.
// First sample and disabled samples skip both sides: accept, then result.
// Reset: rst_n synchronous, active low; clears timers and button history, restores config defaults.
// Stalls: the result sits in an output register; a new sample is taken while it
//   waits, and the next result holds in the final state until the slot frees.

`include "accelerating_autorepeat_stepper_defines.svh"

module accelerating_autorepeat_stepper #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  aas_in_if.sink                         in_ch,
  aas_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aas_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam logic [TIME_WIDTH-1:0] TIME_ZERO = '0;

  aas_pkg::top_state_t state_r, state_nxt;
  aas_pkg::cfg_view_t  view;
  aas_pkg::ivl_req_t   iv_req;
  aas_pkg::ivl_rsp_t   iv_rsp;

  // sequencing / history
  logic side_r, side_nxt;            // 0: up side, 1: down side
  logic started_r, started_nxt;
  logic up_was_r, up_was_nxt;
  logic down_was_r, down_was_nxt;
  logic [TIME_WIDTH-1:0] up_hold_r, up_hold_nxt;
  logic [TIME_WIDTH-1:0] up_next_r, up_next_nxt;
  logic [TIME_WIDTH-1:0] down_hold_r, down_hold_nxt;
  logic [TIME_WIDTH-1:0] down_next_r, down_next_nxt;

  // sample being worked on
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic                  up_r, up_nxt;
  logic                  down_r, down_nxt;
  logic signed [15:0]    val_r, val_nxt;
  logic                  chg_r, chg_nxt;

  // result slot
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_value_r, out_value_nxt;
  logic               out_chg_r, out_chg_nxt;

  logic in_rdy, in_acc;

  // current-side view
  logic                  s_pressed, s_was, s_due, s_step, s_first;
  logic [TIME_WIDTH-1:0] s_hold, s_next, s_held;
  logic [1:0]            s_mult;      // 0..3 means x1..x4
  logic [16:0]           s_mag;
  logic signed [18:0]    s_raw;
  logic signed [15:0]    s_val;
  logic signed [15:0]    in_clamped;

  // timer write-back for the current side
  logic                  t_wr;
  logic [TIME_WIDTH-1:0] t_hold, t_next;
  logic                  advance;

  aas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .commit  (in_acc),
    .view    (view)
  );

  aas_ivl_unit u_ivl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iv_req),
    .rsp   (iv_rsp)
  );

  assign in_rdy      = (state_r == aas_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_value     = out_value_r;
  assign out_ch.value_changed = out_chg_r;

  // incoming value clamped into the (already swapped) range
  assign in_clamped = ($signed(in_ch.current_value) < view.lo) ? view.lo :
                      ($signed(in_ch.current_value) > view.hi) ? view.hi :
                      in_ch.current_value;

  assign s_pressed = side_r ? down_r : up_r;
  assign s_was     = side_r ? down_was_r : up_was_r;
  assign s_hold    = side_r ? down_hold_r : up_hold_r;
  assign s_next    = side_r ? down_next_r : up_next_r;
  assign s_due     = (s_next != TIME_ZERO) && (now_r >= s_next);
  assign s_held    = (now_r >= s_hold) ? (now_r - s_hold) : TIME_ZERO;
  assign s_first   = s_pressed && !s_was;
  assign s_step    = s_pressed && (!s_was || s_due);

  // hold multiplier from held time
  always_comb begin
    if (s_first || (s_held < TIME_WIDTH'(aas_pkg::MULT2_MS))) begin
      s_mult = 2'd0;
    end else if (s_held < TIME_WIDTH'(aas_pkg::RAMP_MS)) begin
      s_mult = 2'd1;
    end else if (s_held < TIME_WIDTH'(aas_pkg::MULT4_MS)) begin
      s_mult = 2'd2;
    end else begin
      s_mult = 2'd3;
    end
  end

  always_comb begin
    case (s_mult)
      2'd0:    s_mag = {2'd0, view.step};
      2'd1:    s_mag = {1'b0, view.step, 1'b0};
      2'd2:    s_mag = {2'd0, view.step} + {1'b0, view.step, 1'b0};
      default: s_mag = {view.step, 2'b00};
    endcase
  end

  // 19-bit signed sum cannot wrap; clamp to range
  assign s_raw = side_r ? (19'(val_r) - $signed({2'b00, s_mag}))
                        : (19'(val_r) + $signed({2'b00, s_mag}));
  assign s_val = (s_raw < 19'(view.lo)) ? view.lo :
                 (s_raw > 19'(view.hi)) ? view.hi : s_raw[15:0];

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    started_nxt   = started_r;
    up_was_nxt    = up_was_r;
    down_was_nxt  = down_was_r;
    up_hold_nxt   = up_hold_r;
    up_next_nxt   = up_next_r;
    down_hold_nxt = down_hold_r;
    down_next_nxt = down_next_r;
    now_nxt       = now_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    val_nxt       = val_r;
    chg_nxt       = chg_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_chg_nxt   = out_chg_r;
    iv_req.start  = 1'b0;
    iv_req.held   = s_held[10:0];
    t_wr          = 1'b0;
    t_hold        = s_hold;
    t_next        = s_next;
    advance       = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      aas_pkg::ST_IDLE: begin
        if (in_acc) begin
          now_nxt  = TIME_WIDTH'(in_ch.now_ms);
          up_nxt   = in_ch.up_pressed;
          down_nxt = in_ch.down_pressed;
          val_nxt  = in_clamped;
          chg_nxt  = 1'b0;
          side_nxt = 1'b0;
          if (!started_r) begin
            state_nxt = aas_pkg::ST_DONE;   // first sample: history only
          end else if (!view.enabled) begin
            up_hold_nxt   = TIME_ZERO;
            up_next_nxt   = TIME_ZERO;
            down_hold_nxt = TIME_ZERO;
            down_next_nxt = TIME_ZERO;
            state_nxt     = aas_pkg::ST_DONE;
          end else begin
            state_nxt = aas_pkg::ST_SIDE;
          end
        end
      end
      aas_pkg::ST_SIDE: begin
        if (s_step) begin
          val_nxt = s_val;
          if (s_val != val_r) begin
            chg_nxt = 1'b1;
          end
        end
        if (!s_pressed) begin
          // released: disarm
          t_wr    = 1'b1;
          t_hold  = TIME_ZERO;
          t_next  = TIME_ZERO;
          advance = 1'b1;
        end else if (!s_was) begin
          // press edge: arm first repeat
          t_wr    = 1'b1;
          t_hold  = now_r;
          t_next  = now_r + TIME_WIDTH'(aas_pkg::HOLD_DELAY_MS);
          advance = 1'b1;
        end else if (s_due) begin
          if (s_held == TIME_ZERO) begin
            t_wr    = 1'b1;
            t_next  = now_r + TIME_WIDTH'(aas_pkg::REPEAT_SLOW_MS);
            advance = 1'b1;
          end else if (s_held >= TIME_WIDTH'(aas_pkg::RAMP_MS)) begin
            t_wr    = 1'b1;
            t_next  = now_r + TIME_WIDTH'(aas_pkg::REPEAT_FAST_MS);
            advance = 1'b1;
          end else begin
            iv_req.start = 1'b1;
            state_nxt    = aas_pkg::ST_WAIT;
          end
        end else begin
          advance = 1'b1;
        end
      end
      aas_pkg::ST_WAIT: begin
        if (iv_rsp.done) begin
          t_wr    = 1'b1;
          t_next  = now_r + TIME_WIDTH'(iv_rsp.interval);
          advance = 1'b1;
        end
      end
      aas_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = val_r;
          out_chg_nxt   = chg_r;
          started_nxt   = 1'b1;
          up_was_nxt    = up_r;
          down_was_nxt  = down_r;
          state_nxt     = aas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aas_pkg::ST_IDLE;
    endcase

    if (t_wr) begin
      if (side_r) begin
        down_hold_nxt = t_hold;
        down_next_nxt = t_next;
      end else begin
        up_hold_nxt = t_hold;
        up_next_nxt = t_next;
      end
    end

    if (advance) begin
      if (side_r) begin
        state_nxt = aas_pkg::ST_DONE;
      end else begin
        side_nxt  = 1'b1;
        state_nxt = aas_pkg::ST_SIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aas_pkg::ST_IDLE;
      side_r      <= 1'b0;
      started_r   <= 1'b0;
      up_was_r    <= 1'b0;
      down_was_r  <= 1'b0;
      up_hold_r   <= '0;
      up_next_r   <= '0;
      down_hold_r <= '0;
      down_next_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      started_r   <= started_nxt;
      up_was_r    <= up_was_nxt;
      down_was_r  <= down_was_nxt;
      up_hold_r   <= up_hold_nxt;
      up_next_r   <= up_next_nxt;
      down_hold_r <= down_hold_nxt;
      down_next_r <= down_next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    up_r        <= up_nxt;
    down_r      <= down_nxt;
    val_r       <= val_nxt;
    chg_r       <= chg_nxt;
    out_value_r <= out_value_nxt;
    out_chg_r   <= out_chg_nxt;
  end

  `AAS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_rdy, "sample taken while still busy")
  `AAS_ASSERT_SAME(a_ivl_done_in_wait, iv_rsp.done, state_r == aas_pkg::ST_WAIT, "interval done outside wait")
  `AAS_ASSERT_SAME(a_out_in_range, out_valid_r, ($signed(out_value_r) >= view.lo) && ($signed(out_value_r) <= view.hi), "result outside range")

endmodule

// ===== hdl/aas_cfg_regs.sv =====
module aas_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aas_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           commit,
  output aas_pkg::cfg_view_t             view
);

  logic [15:0] min_r, max_r;
  logic [14:0] step_r;
  logic        en_r;
  logic        swap;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // effective range: reversed bounds are swapped, zero step acts as one
  assign swap         = $signed(max_r) < $signed(min_r);
  assign view.lo      = swap ? max_r : min_r;
  assign view.hi      = swap ? min_r : max_r;
  assign view.step    = (step_r == 15'd0) ? 15'd1 : step_r;
  assign view.enabled = en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= 16'd0;
      max_r  <= 16'd100;
      step_r <= 15'd1;
      en_r   <= 1'b1;
    end else if (wr) begin
      unique case (paddr[3:2])
        aas_pkg::REG_MIN_VALUE: min_r  <= pwdata[15:0];
        aas_pkg::REG_MAX_VALUE: max_r  <= pwdata[15:0];
        aas_pkg::REG_STEP_SIZE: step_r <= pwdata[14:0];
        aas_pkg::REG_ENABLED:   en_r   <= pwdata[0];
        default: ;
      endcase
    end else if (commit) begin
      // fixups stick in the registers
      min_r  <= view.lo;
      max_r  <= view.hi;
      step_r <= view.step;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      aas_pkg::REG_MIN_VALUE: prdata = {16'd0, min_r};
      aas_pkg::REG_MAX_VALUE: prdata = {16'd0, max_r};
      aas_pkg::REG_STEP_SIZE: prdata = {17'd0, step_r};
      aas_pkg::REG_ENABLED:   prdata = {31'd0, en_r};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/aas_mul_unit.sv =====
module aas_mul_unit (
  input  logic                        clk,
  input  logic                        en,
  input  logic [aas_pkg::MUL_A_W-1:0] a,
  input  logic [aas_pkg::MUL_B_W-1:0] b,
  output logic [aas_pkg::MUL_P_W-1:0] p_r
);

  logic [aas_pkg::MUL_P_W-1:0] p_nxt;

  assign p_nxt = {{aas_pkg::MUL_B_W{1'b0}}, a} * {{aas_pkg::MUL_A_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ===== hdl/aas_ivl_unit.sv =====
// Repeat interval for 0 < held < 1200 ms, ease-out cubic, four multiplies.
module aas_ivl_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  aas_pkg::ivl_req_t req,
  output aas_pkg::ivl_rsp_t rsp
);

  aas_pkg::ivl_state_t state_r, state_nxt;
  logic [16:0] u_r, u_nxt;

  logic                        mul_en;
  logic [aas_pkg::MUL_A_W-1:0] mul_a;
  logic [aas_pkg::MUL_B_W-1:0] mul_b;
  logic [aas_pkg::MUL_P_W-1:0] mul_p;

  logic [22:0] ramp_num;
  logic [16:0] t_q16;
  logic [48:0] cube_rnd;
  logic [22:0] scale_rnd;

  aas_mul_unit u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign ramp_num  = {req.held, 12'd0} + 23'(aas_pkg::RAMP_BIAS);
  assign t_q16     = mul_p[45:29];
  assign cube_rnd  = mul_p[48:0] + 49'h0_8000_0000;
  assign scale_rnd = mul_p[22:0] + 23'h8000;

  assign rsp.done     = (state_r == aas_pkg::IV_FIN);
  assign rsp.interval = aas_pkg::REPEAT_FAST_MS + scale_rnd[22:16];

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      aas_pkg::IV_IDLE: begin
        if (req.start) begin
          mul_en    = 1'b1;
          mul_a     = aas_pkg::MUL_A_W'(ramp_num);
          mul_b     = aas_pkg::RECIP_75;
          state_nxt = aas_pkg::IV_SQUARE;
        end
      end
      aas_pkg::IV_SQUARE: begin
        // u = 1 - t in Q0.16
        u_nxt     = 17'h10000 - t_q16;
        mul_en    = 1'b1;
        mul_a     = aas_pkg::MUL_A_W'(u_nxt);
        mul_b     = aas_pkg::MUL_B_W'(u_nxt);
        state_nxt = aas_pkg::IV_CUBE;
      end
      aas_pkg::IV_CUBE: begin
        mul_en    = 1'b1;
        mul_a     = mul_p[31:0];
        mul_b     = aas_pkg::MUL_B_W'(u_r);
        state_nxt = aas_pkg::IV_SCALE;
      end
      aas_pkg::IV_SCALE: begin
        mul_en    = 1'b1;
        mul_a     = aas_pkg::MUL_A_W'(cube_rnd[48:32]);
        mul_b     = aas_pkg::MUL_B_W'(aas_pkg::EASE_SPAN);
        state_nxt = aas_pkg::IV_FIN;
      end
      aas_pkg::IV_FIN: begin
        state_nxt = aas_pkg::IV_IDLE;
      end
      default: state_nxt = aas_pkg::IV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aas_pkg::IV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
  end

endmodule

// ===== verif/accelerating_autorepeat_stepper_tb.sv =====
`timescale 1ns / 1ps

module accelerating_autorepeat_stepper_tb;

  // Timing of the auto-repeat, in ms.
  localparam int ARM_DELAY_MS = 420;
  localparam int GAP_SLOW_MS  = 92;
  localparam int GAP_FAST_MS  = 36;
  localparam int EASE_RAMP_MS = 1200;
  localparam int GAIN2_MS     = 700;
  localparam int GAIN4_MS     = 1800;

  localparam int SIDE_UP   = 0;
  localparam int SIDE_DOWN = 1;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        up;
    logic        down;
    logic [15:0] cur;
  } sample_t;

  typedef struct packed {
    logic [15:0] new_value;
    logic        value_changed;
  } result_t;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] data;
    sample_t     smp;
    bit          typed;    // expected result written into the row
    result_t     want;
  } row_t;

  // Receiver pacing patterns.
  typedef enum {SINK_OPEN, SINK_COIN, SINK_BEAT, SINK_TRICKLE} sink_mode_e;

  logic clk;
  logic rst_n;

  aas_in_if  in_ch ();
  aas_out_if out_ch ();

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [aas_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]                    cfg_pwdata;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  accelerating_autorepeat_stepper u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run (every repeat on the interval
  // path, plus sender gaps, receiver stalls and the two long hold-offs).
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stepper mirror: register copy and per-button history.
  // ---------------------------------------------------------------------
  logic [15:0] cfg_lo   = 16'd0;
  logic [15:0] cfg_hi   = 16'd100;
  logic [14:0] cfg_step = 15'd1;
  logic        cfg_en   = 1'b1;

  logic        seen_first = 1'b0;
  logic        prev_lvl[2] = '{1'b0, 1'b0};
  logic [31:0] hold_since[2] = '{32'd0, 32'd0};
  logic [31:0] repeat_due[2] = '{32'd0, 32'd0};   // zero = no repeat armed

  result_t     pending_values[$];   // expected results, oldest first
  int          mismatches = 0;

  row_t        plan[$];
  bit          offering = 1'b0;     // valid held high by the sender
  int          burst_left = 0;
  logic [15:0] last_value = 16'd0;  // fed back as the next current value

  // One button side: press edge steps and arms, held button repeats when due.
  function automatic void run_button(input int k, input logic pressed,
                                     input logic [31:0] now, input int delta,
                                     input int lo, input int hi,
                                     inout int v, inout logic moved);
    logic [31:0]     h;
    longint unsigned t, u, c;
    int              amount, raw, gap_ms, gain;
    bit              act;
    act = 1'b0;
    amount = 0;
    if (!pressed) begin
      hold_since[k] = '0;
      repeat_due[k] = '0;
    end else if (!prev_lvl[k]) begin
      act = 1'b1;
      amount = delta;
      hold_since[k] = now;
      repeat_due[k] = now + ARM_DELAY_MS;   // may wrap to zero: disarmed
    end else if (repeat_due[k] != 0 && now >= repeat_due[k]) begin
      h = (now >= hold_since[k]) ? now - hold_since[k] : 32'd0;
      // hold multiplier
      if (h < GAIN2_MS) gain = 1;
      else if (h < EASE_RAMP_MS) gain = 2;
      else if (h < GAIN4_MS) gain = 3;
      else gain = 4;
      // ease-out-cubic interval in Q0.16, round half up
      if (h == 0) begin
        gap_ms = GAP_SLOW_MS;
      end else begin
        if (h >= EASE_RAMP_MS) t = 64'd65536;
        else t = (longint'(h) * 65536 + 600) / 1200;
        u = 64'd65536 - t;
        c = (u * u * u + 64'h8000_0000) >> 32;
        gap_ms = GAP_FAST_MS + int'(((GAP_SLOW_MS - GAP_FAST_MS) * c + 32768) >> 16);
      end
      act = 1'b1;
      amount = delta * gain;
      repeat_due[k] = now + gap_ms;
    end
    if (act) begin
      raw = v + amount;   // 32-bit sum, clamped rather than wrapped
      if (raw < lo) raw = lo;
      if (raw > hi) raw = hi;
      if (raw != v) begin
        v = raw;
        moved = 1'b1;
      end
    end
  endfunction

  // Result of one sample; advances the mirrored state.
  function automatic result_t predict_step(input sample_t s);
    logic [15:0] swap_tmp;
    int          lo, hi, v, st;
    logic        moved;
    result_t     r;
    if ($signed(cfg_hi) < $signed(cfg_lo)) begin
      swap_tmp = cfg_lo;   // reversed range stays swapped
      cfg_lo = cfg_hi;
      cfg_hi = swap_tmp;
    end
    if (cfg_step == 0) cfg_step = 15'd1;
    lo = $signed(cfg_lo);
    hi = $signed(cfg_hi);
    st = cfg_step;
    v = $signed(s.cur);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    moved = 1'b0;
    if (!seen_first) begin
      seen_first = 1'b1;   // first sample only records the buttons
    end else if (cfg_en) begin
      run_button(SIDE_UP, s.up, s.now_ms, st, lo, hi, v, moved);
      run_button(SIDE_DOWN, s.down, s.now_ms, -st, lo, hi, v, moved);
    end else begin
      hold_since[SIDE_UP] = '0;
      repeat_due[SIDE_UP] = '0;
      hold_since[SIDE_DOWN] = '0;
      repeat_due[SIDE_DOWN] = '0;
    end
    prev_lvl[SIDE_UP] = s.up;
    prev_lvl[SIDE_DOWN] = s.down;
    r.new_value = v[15:0];
    r.value_changed = moved;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------
  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, data: data, smp: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void add_smp(input logic [31:0] now, input logic up,
                                  input logic down, input logic [15:0] cur,
                                  input bit typed, input logic [15:0] want_val,
                                  input logic want_chg);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.reg_idx = aas_pkg::REG_MIN_VALUE;
    r.data = '0;
    r.smp = '{now_ms: now, up: up, down: down, cur: cur};
    r.typed = typed;
    r.want = '{new_value: want_val, value_changed: want_chg};
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offer one sample, wait for the transfer, predict, then pace.
  // ---------------------------------------------------------------------
  task automatic offer(input sample_t s, input bit typed, input result_t want);
    result_t r;
    int      gap;
    in_ch.valid         <= 1'b1;
    in_ch.now_ms        <= s.now_ms;
    in_ch.up_pressed    <= s.up;
    in_ch.down_pressed  <= s.down;
    in_ch.current_value <= s.cur;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_step(s);
    last_value = r.new_value;
    pending_values.push_back(typed ? want : r);
    // bursts of random length, random gaps between them
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and drain every outstanding result.
  task automatic settle();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then back to idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      aas_pkg::REG_MIN_VALUE: cfg_lo = data[15:0];
      aas_pkg::REG_MAX_VALUE: cfg_hi = data[15:0];
      aas_pkg::REG_STEP_SIZE: cfg_step = data[14:0];
      aas_pkg::REG_ENABLED:   cfg_en = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every transfer on the output against the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_values.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result new_value %0d value_changed %0b",
                 $time, $signed(out_ch.new_value), out_ch.value_changed);
      end else begin
        want = pending_values.pop_front();
        if (out_ch.new_value !== want.new_value) begin
          mismatches++;
          $display("%0t: new_value expected %0d, got %0d", $time,
                   $signed(want.new_value), $signed(out_ch.new_value));
        end
        if (out_ch.value_changed !== want.value_changed) begin
          mismatches++;
          $display("%0t: value_changed expected %0b, got %0b", $time,
                   want.value_changed, out_ch.value_changed);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: changing stall patterns plus two long hold-offs so the
  // block fills up and backs up its input.
  // ---------------------------------------------------------------------
  initial begin : sink_pacing
    int         cyc;
    int         mode_left;
    int         hold_left;
    sink_mode_e mode;
    cyc = 0;
    mode_left = 0;
    hold_left = 0;
    mode = SINK_OPEN;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 15000) hold_left = 400;
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:    out_ch.ready <= 1'b1;
          SINK_COIN:    out_ch.ready <= $urandom_range(0, 1);
          SINK_BEAT:    out_ch.ready <= (cyc % 5) < 3;
          SINK_TRICKLE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:      out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------
  initial begin : main_seq
    sample_t     s;
    int          p, i, count, roll;
    logic [31:0] lo_w, hi_w, st_w, en_w;
    logic [31:0] clock_ms;
    logic        up_lvl, down_lvl;
    int          up_left, down_left;

    clock_ms = 32'd5000;
    up_lvl = 1'b0;
    down_lvl = 1'b0;
    up_left = 0;
    down_left = 0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.now_ms        <= '0;
    in_ch.up_pressed    <= 1'b0;
    in_ch.down_pressed  <= 1'b0;
    in_ch.current_value <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;

    // Directed table. Expected results typed in only where obvious.
    // first sample: records buttons, value just clamped
    add_smp(32'd1000, 1'b0, 1'b0, -16'sd5, 1'b1, 16'd0, 1'b0);
    // press edge, then held before the 420 ms arm delay
    add_smp(32'd1010, 1'b1, 1'b0, 16'd50, 1'b1, 16'd51, 1'b1);
    add_smp(32'd1020, 1'b1, 1'b0, 16'd51, 1'b1, 16'd51, 1'b0);
    // first repeat exactly at the arm time
    add_smp(32'd1430, 1'b1, 1'b0, 16'd51, 1'b1, 16'd52, 1'b1);
    // repeats at growing hold times: x2, x3, then x4 clamped at the top
    add_smp(32'd1900, 1'b1, 1'b0, 16'd52, 1'b0, 16'd0, 1'b0);
    add_smp(32'd2500, 1'b1, 1'b0, 16'd54, 1'b0, 16'd0, 1'b0);
    add_smp(32'd3500, 1'b1, 1'b0, 16'd99, 1'b1, 16'd100, 1'b1);
    // release up, press down
    add_smp(32'd3600, 1'b0, 1'b1, 16'd100, 1'b1, 16'd99, 1'b1);
    add_smp(32'd3620, 1'b0, 1'b0, 16'd50, 1'b1, 16'd50, 1'b0);
    // both pressed at once: steps cancel, still flagged as changed
    add_smp(32'd3630, 1'b1, 1'b1, 16'd50, 1'b1, 16'd50, 1'b1);
    add_smp(32'd3640, 1'b0, 1'b0, 16'd50, 1'b1, 16'd50, 1'b0);
    // full range, largest step: sum saturates instead of wrapping
    add_cfg(aas_pkg::REG_MIN_VALUE, 32'hFFFF_8000);
    add_cfg(aas_pkg::REG_MAX_VALUE, 32'h0000_7FFF);
    add_cfg(aas_pkg::REG_STEP_SIZE, 32'h0000_7FFF);
    add_smp(32'd4000, 1'b1, 1'b0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0);
    add_smp(32'd4010, 1'b0, 1'b1, 16'h8000, 1'b1, 16'h8000, 1'b0);
    add_smp(32'd4020, 1'b1, 1'b0, 16'd0, 1'b1, 16'h7FFF, 1'b1);
    add_smp(32'd4030, 1'b0, 1'b0, 16'd0, 1'b1, 16'd0, 1'b0);
    // reversed range gets swapped; zero step acts as one
    add_cfg(aas_pkg::REG_MIN_VALUE, 32'd100);
    add_cfg(aas_pkg::REG_MAX_VALUE, 32'hFFFF_FF9C);
    add_cfg(aas_pkg::REG_STEP_SIZE, 32'd0);
    add_smp(32'd4040, 1'b0, 1'b0, 16'd200, 1'b1, 16'd100, 1'b0);
    add_smp(32'd4050, 1'b0, 1'b1, 16'd0, 1'b1, 16'hFFFF, 1'b1);
    // disabled: no step, button levels still recorded
    add_cfg(aas_pkg::REG_ENABLED, 32'd0);
    add_smp(32'd4060, 1'b1, 1'b1, 16'd500, 1'b1, 16'd100, 1'b0);
    add_cfg(aas_pkg::REG_ENABLED, 32'd1);
    add_smp(32'd4070, 1'b1, 1'b0, 16'd10, 1'b1, 16'd10, 1'b0);
    add_smp(32'd4080, 1'b0, 1'b0, 16'd10, 1'b1, 16'd10, 1'b0);
    // time wrap: arm time lands exactly on zero and disarms
    add_smp(32'hFFFF_FE5C, 1'b1, 1'b0, 16'd10, 1'b1, 16'd11, 1'b1);
    add_smp(32'hFFFF_FFF0, 1'b1, 1'b0, 16'd11, 1'b1, 16'd11, 1'b0);
    add_smp(32'hFFFF_FF00, 1'b0, 1'b0, 16'd11, 1'b1, 16'd11, 1'b0);
    // time wrap: wrapped arm time is small, so the repeat fires at once
    add_smp(32'hFFFF_FF00, 1'b1, 1'b0, 16'd11, 1'b1, 16'd12, 1'b1);
    add_smp(32'hFFFF_FF10, 1'b1, 1'b0, 16'd12, 1'b1, 16'd13, 1'b1);
    add_smp(32'h0000_0010, 1'b1, 1'b0, 16'd13, 1'b0, 16'd0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[k].reg_idx, plan[k].data);
      end else begin
        offer(plan[k].smp, plan[k].typed, plan[k].want);
      end
    end

    // Random phases, each under its own register setting.
    for (p = 0; p < 8; p++) begin
      settle();
      en_w = 32'd1;
      case (p)
        0: begin lo_w = 32'd0; hi_w = 32'd100; st_w = 32'd1; end
        1: begin lo_w = 32'hFFFF_8000; hi_w = 32'h7FFF; st_w = 32'h7FFF; end
        2: begin lo_w = 32'hFFFF_8000; hi_w = 32'h7FFF; st_w = 32'd1; end
        3: begin   // reversed range, zero step
          lo_w = $urandom_range(0, 30000);
          hi_w = -$urandom_range(0, 30000);
          st_w = 32'd0;
        end
        default: begin
          lo_w = $urandom_range(0, 65535);
          hi_w = $urandom_range(0, 65535);
          st_w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                              : $urandom_range(1, 20);
          if (p == 4) en_w = 32'd0;
        end
      endcase
      cfg_write(aas_pkg::REG_MIN_VALUE, lo_w);
      cfg_write(aas_pkg::REG_MAX_VALUE, hi_w);
      cfg_write(aas_pkg::REG_STEP_SIZE, st_w);
      cfg_write(aas_pkg::REG_ENABLED, en_w);

      count = (p == 4) ? 60 : 240;
      for (i = 0; i < count; i++) begin
        // mostly a clock running forward at human rates; rare jumps
        roll = $urandom_range(0, 999);
        if (roll < 10) clock_ms = $urandom();
        else if (roll < 15) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else if (roll < 25) clock_ms = clock_ms - $urandom_range(1, 200);
        else if (roll < 125) clock_ms = clock_ms + $urandom_range(61, 600);
        else clock_ms = clock_ms + $urandom_range(0, 60);
        // long holds reach the x4 multiplier, short releases between
        if (up_left == 0) begin
          up_lvl = ~up_lvl;
          up_left = up_lvl ? $urandom_range(1, 120) : $urandom_range(1, 15);
        end
        up_left--;
        if (down_left == 0) begin
          down_lvl = ~down_lvl;
          down_left = down_lvl ? $urandom_range(1, 80) : $urandom_range(1, 40);
        end
        down_left--;
        s.now_ms = clock_ms;
        s.up = up_lvl;
        s.down = down_lvl;
        // occasional glitch on a button level
        if ($urandom_range(0, 49) == 0) s.up = ~s.up;
        if ($urandom_range(0, 49) == 0) s.down = ~s.down;
        s.cur = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : last_value;
        offer(s, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
